// ===== hw/rtl/lzw_compressor_macros.svh =====
// Assertion helpers for the LZW encoder.
`ifndef LZW_COMPRESSOR_MACROS_SVH
`define LZW_COMPRESSOR_MACROS_SVH

// cond must hold on every clock edge outside reset
`define LZWC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// ante implies cons in the same cycle
`define LZWC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lzwc_pkg.sv =====
`timescale 1ns / 1ps

package lzwc_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int CODE_W       = 12;
    localparam int BYTE_W       = 8;
    localparam int NFC_W        = CODE_W + 1;
    localparam int ENTRY_W      = CODE_W + BYTE_W;
    localparam int CODE_BASE    = 256;
    localparam int CODE_SPACE   = 1 << CODE_W;
    localparam int DICT_DEPTH   = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
    localparam int DICT_AW      = $clog2(DICT_DEPTH);

    localparam logic [CODE_W-1:0] MAX_CODE_RST = CODE_W'(CODE_SPACE - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_EMIT_A = 4'b0100,
        S_EMIT_B = 4'b1000
    } t_state;

endpackage

// ===== hw/rtl/lzwc_ram.sv =====
`timescale 1ns / 1ps

module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lzw_compressor.sv =====
// LZW encoder, 12-bit codes.
// Input channel: i_in_valid / o_in_stall with i_data_byte and i_last_byte, one byte a beat.
// Output channel: o_out_valid / i_out_stall with o_code and o_last_code, one code a beat.
// Config channel: i_cfg_valid / o_cfg_ready writes max_code; write only while idle.
// Each byte is looked up by a linear scan of the dictionary RAM, one entry per cycle
// through a single comparator. A match ends the scan at its entry; a miss scans every
// entry in use. The first byte of a message needs no scan. A last byte also yields an end code.
// A miss adds the new pair in the same cycle, if the dictionary has room.
// A byte yields zero, one or two codes, each loaded into the output register,
// and o_in_stall stays high until all of the byte's codes are loaded.
// The output register lets a new byte be taken while a code waits; if the receiver
// stalls, the block holds the code and stops before loading the next one.
// Reset (synchronous, active low) empties the dictionary, drops the prefix and sets
// max_code to 4095; no RAM clearing is needed. The last byte of a message flushes the
// prefix with o_last_code high and restarts the dictionary for the next message.
`timescale 1ns / 1ps

module lzw_compressor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lzwc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_last_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lzwc_pkg::CODE_W-1:0] o_code,
    output logic                        o_last_code,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lzwc_pkg::CODE_W-1:0] i_cfg_max_code
);

    import lzwc_pkg::*;

    t_state              r_state,       n_state;
    logic [CODE_W-1:0]   r_max_code,    n_max_code;
    logic [CODE_W-1:0]   r_prefix,      n_prefix;
    logic                r_prefix_valid, n_prefix_valid;
    logic [NFC_W-1:0]    r_next_free,   n_next_free;
    logic [NFC_W-1:0]    r_scan,        n_scan;
    logic                r_pend,        n_pend;
    logic [CODE_W-1:0]   r_rd_code,     n_rd_code;
    logic [BYTE_W-1:0]   r_byte,        n_byte;
    logic                r_last,        n_last;
    logic [CODE_W-1:0]   r_a_code,      n_a_code;
    logic                r_a_last,      n_a_last;
    logic                r_two,         n_two;
    logic                r_out_valid,   n_out_valid;
    logic [CODE_W-1:0]   r_out_code,    n_out_code;
    logic                r_out_last,    n_out_last;

    logic                ram_we;
    logic [DICT_AW-1:0]  ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [ENTRY_W-1:0]  key;
    logic                hit;
    logic                more;
    logic                can_add;
    logic                out_free;
    logic [CODE_W-1:0]   byte_code;
    logic [CODE_W-1:0]   in_code;

    lzwc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_next_free[DICT_AW-1:0]),
        .i_wdata (key),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign key       = {r_prefix, r_byte};
    assign ram_raddr = r_scan[DICT_AW-1:0];
    assign hit       = r_pend && (ram_rdata == key);
    assign more      = r_scan < r_next_free;
    assign can_add   = (r_next_free <= {1'b0, r_max_code}) &&
                       (r_next_free < NFC_W'(DICT_DEPTH));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign byte_code = {{(CODE_W-BYTE_W){1'b0}}, r_byte};
    assign in_code   = {{(CODE_W-BYTE_W){1'b0}}, i_data_byte};

    always_comb begin
        n_state        = r_state;
        n_max_code     = r_max_code;
        n_prefix       = r_prefix;
        n_prefix_valid = r_prefix_valid;
        n_next_free    = r_next_free;
        n_scan         = r_scan;
        n_pend         = r_pend;
        n_rd_code      = r_rd_code;
        n_byte         = r_byte;
        n_last         = r_last;
        n_a_code       = r_a_code;
        n_a_last       = r_a_last;
        n_two          = r_two;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_code     = r_out_code;
        n_out_last     = r_out_last;
        ram_we         = 1'b0;

        if (i_cfg_valid) begin
            n_max_code = i_cfg_max_code;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_data_byte;
                    n_last = i_last_byte;
                    if (!r_prefix_valid) begin
                        if (i_last_byte) begin
                            n_a_code = in_code;
                            n_a_last = 1'b1;
                            n_two    = 1'b0;
                            n_prefix = '0;
                            n_state  = S_EMIT_A;
                        end else begin
                            n_prefix       = in_code;
                            n_prefix_valid = 1'b1;
                        end
                    end else begin
                        n_scan  = NFC_W'(CODE_BASE);
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_pend = 1'b0;
                    if (r_last) begin
                        n_a_code       = r_rd_code;
                        n_a_last       = 1'b1;
                        n_two          = 1'b0;
                        n_prefix       = '0;
                        n_prefix_valid = 1'b0;
                        n_next_free    = NFC_W'(CODE_BASE);
                        n_state        = S_EMIT_A;
                    end else begin
                        n_prefix = r_rd_code;
                        n_state  = S_IDLE;
                    end
                end else if (!more) begin
                    n_pend   = 1'b0;
                    n_a_code = r_prefix;
                    n_a_last = 1'b0;
                    n_two    = r_last;
                    n_prefix = byte_code;
                    if (can_add) begin
                        ram_we      = 1'b1;
                        n_next_free = r_next_free + 1'b1;
                    end
                    if (r_last) begin
                        n_prefix       = '0;
                        n_prefix_valid = 1'b0;
                        n_next_free    = NFC_W'(CODE_BASE);
                    end
                    n_state = S_EMIT_A;
                end else begin
                    n_pend    = 1'b1;
                    n_rd_code = r_scan[CODE_W-1:0];
                    n_scan    = r_scan + 1'b1;
                end
            end
            S_EMIT_A: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_a_code;
                    n_out_last  = r_a_last;
                    n_state     = r_two ? S_EMIT_B : S_IDLE;
                end
            end
            S_EMIT_B: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = byte_code;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_max_code     <= MAX_CODE_RST;
            r_prefix       <= '0;
            r_prefix_valid <= 1'b0;
            r_next_free    <= NFC_W'(CODE_BASE);
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_max_code     <= n_max_code;
            r_prefix       <= n_prefix;
            r_prefix_valid <= n_prefix_valid;
            r_next_free    <= n_next_free;
            r_pend         <= n_pend;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_rd_code  <= n_rd_code;
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_a_code   <= n_a_code;
        r_a_last   <= n_a_last;
        r_two      <= n_two;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_code      = r_out_code;
    assign o_last_code = r_out_last;
    assign o_cfg_ready = 1'b1;

`include "lzw_compressor_macros.svh"

    `LZWC_ASSERT_ALWAYS(a_next_free_range, (r_next_free >= NFC_W'(CODE_BASE)) && (r_next_free <= NFC_W'(DICT_DEPTH)), "next free code out of range")
    `LZWC_ASSERT_IMPLY(a_scan_bound, r_state == S_SCAN, r_scan <= r_next_free, "scan ran past the dictionary")
    `LZWC_ASSERT_IMPLY(a_empty_dict, (r_state == S_IDLE) && !r_prefix_valid, r_next_free == NFC_W'(CODE_BASE), "dictionary not empty at message start")
    `LZWC_ASSERT_IMPLY(a_load_from_emit, $rose(r_out_valid), ($past(r_state) == S_EMIT_A) || ($past(r_state) == S_EMIT_B), "output loaded outside an emit state")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import lzwc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } byte_beat_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } code_beat_t;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [BYTE_W-1:0]   i_data_byte    = '0;
    logic                i_last_byte    = 1'b0;
    logic                i_out_stall    = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic [CODE_W-1:0]   i_cfg_max_code = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [CODE_W-1:0]   o_code;
    logic                o_last_code;
    logic                o_cfg_ready;

    // encoder model state
    logic [CODE_W-1:0]   pfx_code   = '0;
    logic                pfx_held   = 1'b0;
    logic [NFC_W-1:0]    next_code  = NFC_W'(CODE_BASE);
    logic [CODE_W-1:0]   limit_code = MAX_CODE_RST;
    logic [ENTRY_W-1:0]  dict [DICT_ENTRIES];

    byte_beat_t          byte_q [$];
    code_beat_t          code_q [$];
    byte_beat_t          in_beat;
    code_beat_t          exp_beat;
    int                  in_gap     = 0;
    int                  out_hold   = 0;
    bit                  steady_in  = 1'b0;
    bit                  steady_out = 1'b0;
    int                  fail_cnt   = 0;
    int                  cycle_cnt  = 0;

    lzw_compressor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_code         (o_code),
        .o_last_code    (o_last_code),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_max_code (i_cfg_max_code)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void predict_codes(logic [BYTE_W-1:0] b, logic lst);
        logic [ENTRY_W-1:0] key;
        int                 hit;
        code_beat_t         cb;
        hit = -1;
        if (!pfx_held) begin
            pfx_code = CODE_W'(b);
            pfx_held = 1'b1;
        end else begin
            key = {pfx_code, b};
            for (int c = CODE_BASE; c < int'(next_code) && c < DICT_ENTRIES; c++) begin
                if (hit < 0 && dict[DICT_AW'(c)] == key)
                    hit = c;
            end
            if (hit >= 0) begin
                pfx_code = CODE_W'(hit);
            end else begin
                cb.code = pfx_code;
                cb.last = 1'b0;
                code_q = {code_q, cb};
                if (int'(next_code) <= int'(limit_code) && int'(next_code) < CODE_SPACE &&
                    int'(next_code) < DICT_ENTRIES) begin
                    dict[next_code[DICT_AW-1:0]] = key;
                    next_code = next_code + 1'b1;
                end
                pfx_code = CODE_W'(b);
            end
        end
        if (lst) begin
            cb.code = pfx_code;
            cb.last = 1'b1;
            code_q = {code_q, cb};
            pfx_code  = '0;
            pfx_held  = 1'b0;
            next_code = NFC_W'(CODE_BASE);
        end
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_codes(i_data_byte, i_last_byte);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap != 0) begin
                    in_gap = in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    in_beat = byte_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_data_byte <= in_beat.data;
                    i_last_byte <= in_beat.last;
                    in_gap = steady_in ? 0 : $urandom_range(0, 3);
                    if ($urandom_range(0, 39) == 0)
                        steady_in = !steady_in;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (code_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected code beat: code %0d last %0b",
                                 o_code, o_last_code);
                end else begin
                    exp_beat = code_q.pop_front();
                    if (o_code !== exp_beat.code || o_last_code !== exp_beat.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("code mismatch: exp code %0d last %0b, got code %0d last %0b",
                                     exp_beat.code, exp_beat.last, o_code, o_last_code);
                    end
                end
                out_hold = steady_out ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 39) == 0)
                    steady_out = !steady_out;
            end else if (out_hold != 0) begin
                out_hold = out_hold - 1;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** lzw_compressor: FAILED **");
            $finish;
        end
    end

    task automatic write_limit(input logic [CODE_W-1:0] v);
        i_cfg_valid    <= 1'b1;
        i_cfg_max_code <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        limit_code = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || i_in_valid || code_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic push_beat(input logic [BYTE_W-1:0] d, input logic lst);
        byte_beat_t b;
        b.data = d;
        b.last = lst;
        byte_q = {byte_q, b};
    endtask

    // small alphabets give long dictionary matches; n_sym of 0 means any byte
    task automatic queue_message(input int len);
        logic [BYTE_W-1:0] sym [4];
        int                n_sym;
        logic [BYTE_W-1:0] d;
        n_sym = $urandom_range(0, 4);
        foreach (sym[i])
            sym[i] = BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            if (n_sym == 0)
                d = BYTE_W'($urandom_range(0, 255));
            else
                d = sym[2'($urandom_range(0, n_sym - 1))];
            push_beat(d, i == len - 1);
        end
    endtask

    initial begin
        logic [CODE_W-1:0] limits [8];
        int                queued;
        int                len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_limit(MAX_CODE_RST);
        push_beat(8'h00, 1'b1);
        push_beat(8'hFF, 1'b1);
        repeat (5) push_beat(8'h41, 1'b0);
        push_beat(8'h41, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b1);
        for (int i = 0; i < 6; i++)
            push_beat(i[0] ? 8'h62 : 8'h61, 1'b0);
        push_beat(8'h61, 1'b1);
        push_beat(8'h55, 1'b0);
        push_beat(8'hAA, 1'b1);
        wait_drained();

        limits = '{12'd256, 12'd0, 12'd4095, 12'd300, 12'd257, 12'd255, 12'd1000, 12'd2048};
        limits[6] = CODE_W'($urandom_range(256, 4095));
        limits[7] = CODE_W'($urandom_range(256, 4095));
        foreach (limits[p]) begin
            write_limit(limits[p]);
            queued = 0;
            while (queued < 36) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 160)
                                                  : $urandom_range(1, 48);
                queue_message(len);
                queued += len;
            end
            wait_drained();
        end

        if (fail_cnt == 0 && code_q.size() == 0)
            $display("** lzw_compressor: PASSED **");
        else
            $display("** lzw_compressor: FAILED **");
        $finish;
    end

endmodule
